FILE: rtl/core/owbb_pkg.sv
// ----------------------------------------------------------------------------
// owbb_pkg
// Shared widths, request codes and control bundles for the offset window
// byte buffer.
// ----------------------------------------------------------------------------
package owbb_pkg;

	localparam int OWBB_DEPTH    = 4096;
	localparam int OWBB_MAX_READ = 64;

	localparam int TYPE_W    = 2;
	localparam int OFF_W     = 32;
	localparam int LEN_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int OFF_CNT_W = $clog2(OFF_W);

	localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_ERASE = 2'd2;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	typedef struct packed {
		logic load;
		logic status;
		logic last;
	} rsp_ctl_t;

endpackage

FILE: rtl/core/offset_window_byte_buffer_core.sv
// ----------------------------------------------------------------------------
// offset_window_byte_buffer_core
// Byte store addressed by absolute stream offset, holding a sliding window
// in a circular memory, with a registered response stage.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | req_valid, req_stall | req_type, offset, length, data_byte
//  response | rsp_valid, rsp_stall | read_byte, status, last, window_start,
//           |                      | window_used
//
// Requests are handled one at a time; the response register lets a new
// request enter while the last response still waits.
// write: gap, write and response steps, and a zero step per gap byte zeroed;
// into an empty window of non-power-of-two depth, via the offset reduction.
// read: one store read per byte on the single read port, paused by rsp_stall.
// erase: gap, erase and response, plus a zero step per byte zeroed mid-window.
// No clearing pass after reset; unwritten store entries are never read back.
// ----------------------------------------------------------------------------
module offset_window_byte_buffer_core #(
	parameter int DEPTH    = owbb_pkg::OWBB_DEPTH,
	parameter int MAX_READ = owbb_pkg::OWBB_MAX_READ,
	parameter int UW       = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [owbb_pkg::TYPE_W-1:0] req_type,
	input  logic [owbb_pkg::OFF_W-1:0]  offset,
	input  logic [owbb_pkg::LEN_W-1:0]  length,
	input  logic [owbb_pkg::BYTE_W-1:0] data_byte,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [owbb_pkg::BYTE_W-1:0] read_byte,
	output logic                        status,
	output logic                        last,
	output logic [owbb_pkg::OFF_W-1:0]  window_start,
	output logic [UW-1:0]               window_used
);
	import owbb_pkg::*;

	localparam int AW = $clog2(DEPTH);

	rsp_ctl_t          rsp_ctl;
	mem_ctl_t          mem_ctl;
	logic [BYTE_W-1:0] rsp_byte;
	logic [OFF_W-1:0]  win_start;
	logic [UW-1:0]     win_used;
	logic              rsp_free;
	logic              mod_start;
	logic              mod_done;
	logic [AW-1:0]     mod_res;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [BYTE_W-1:0] wdata;
	logic [BYTE_W-1:0] rdata;

	logic              rsp_valid_q;
	logic [BYTE_W-1:0] read_byte_q;
	logic              status_q;
	logic              last_q;
	logic [OFF_W-1:0]  window_start_q;
	logic [UW-1:0]     window_used_q;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	owbb_ctrl #(
		.DEPTH    (DEPTH),
		.MAX_READ (MAX_READ),
		.AW       (AW),
		.UW       (UW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.offset    (offset),
		.length    (length),
		.data_byte (data_byte),
		.rsp_free  (rsp_free),
		.rsp_ctl   (rsp_ctl),
		.rsp_byte  (rsp_byte),
		.win_start (win_start),
		.win_used  (win_used),
		.mod_start (mod_start),
		.mod_done  (mod_done),
		.mod_res   (mod_res),
		.mem_ctl   (mem_ctl),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	owbb_mod_unit #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.din    (offset),
		.done   (mod_done),
		.res    (mod_res)
	);

	owbb_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// response register, refilled in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_ctl.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ctl.load) begin
			read_byte_q    <= rsp_byte;
			status_q       <= rsp_ctl.status;
			last_q         <= rsp_ctl.last;
			window_start_q <= win_start;
			window_used_q  <= win_used;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign read_byte    = read_byte_q;
	assign status       = status_q;
	assign last         = last_q;
	assign window_start = window_start_q;
	assign window_used  = window_used_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (window_used <= UW'(DEPTH)))
		else $error("window used count above depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in progress");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status) |-> (last && read_byte == '0))
		else $error("rejected request must give a single zero response");

endmodule

FILE: rtl/core/owbb_mem.sv
// ----------------------------------------------------------------------------
// owbb_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module owbb_mem #(
	parameter int DEPTH = owbb_pkg::OWBB_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  owbb_pkg::mem_ctl_t         ctl,
	input  logic [AW-1:0]              waddr,
	input  logic [owbb_pkg::BYTE_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [owbb_pkg::BYTE_W-1:0] rdata
);
	import owbb_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/owbb_mod_unit.sv
// ----------------------------------------------------------------------------
// owbb_mod_unit
// Reduction of a stream offset modulo the store depth by reciprocal
// multiplication: a quotient estimate at most one low, then one correcting
// subtract, with the offset, quotient, remainder and result each registered.
// ----------------------------------------------------------------------------
module owbb_mod_unit #(
	parameter int DEPTH = owbb_pkg::OWBB_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [owbb_pkg::OFF_W-1:0] din,
	output logic                      done,
	output logic [AW-1:0]             res
);
	import owbb_pkg::*;

	localparam int              AW1   = AW + 1;
	localparam int              SH    = OFF_W + AW;
	localparam int              MW    = OFF_W + 1;
	// floor(2^SH / DEPTH), below 2^(OFF_W+1) since DEPTH > 2^(AW-1)
	localparam longint unsigned RECIP = (64'd1 << SH) / DEPTH;

	logic                  go_q;
	logic                  v_s1;
	logic                  v_s2;
	logic                  done_q;
	logic [OFF_W-1:0]      x_q;
	logic [OFF_W-1:0]      q_s1;
	logic [AW:0]           rem_s2;
	logic [AW-1:0]         r_q;
	logic [OFF_W+MW-1:0]   prod;
	logic [OFF_W-1:0]      qd;

	always_comb begin
		prod = {{MW{1'b0}}, x_q} * {{OFF_W{1'b0}}, MW'(RECIP)};
		// estimate never exceeds the true quotient, so this cannot overflow
		qd   = q_s1 * OFF_W'(DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q   <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q   <= start;
			v_s1   <= go_q;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= din;
		end
		if (go_q) begin
			q_s1 <= OFF_W'(prod >> SH);
		end
		// remainder estimate lies below twice the depth
		if (v_s1) begin
			rem_s2 <= AW1'(x_q - qd);
		end
		if (v_s2) begin
			r_q <= (rem_s2 >= AW1'(DEPTH)) ? AW'(rem_s2 - AW1'(DEPTH)) : AW'(rem_s2);
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

FILE: rtl/core/owbb_ctrl.sv
// ----------------------------------------------------------------------------
// owbb_ctrl
// Request sequencer: keeps the window registers, decides each request and
// drives the byte store through writes, zero runs and read streams.
// ----------------------------------------------------------------------------
module owbb_ctrl #(
	parameter int DEPTH    = owbb_pkg::OWBB_DEPTH,
	parameter int MAX_READ = owbb_pkg::OWBB_MAX_READ,
	parameter int AW       = $clog2(DEPTH),
	parameter int UW       = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [owbb_pkg::TYPE_W-1:0] req_type,
	input  logic [owbb_pkg::OFF_W-1:0]  offset,
	input  logic [owbb_pkg::LEN_W-1:0]  length,
	input  logic [owbb_pkg::BYTE_W-1:0] data_byte,
	input  logic                        rsp_free,
	output owbb_pkg::rsp_ctl_t          rsp_ctl,
	output logic [owbb_pkg::BYTE_W-1:0] rsp_byte,
	output logic [owbb_pkg::OFF_W-1:0]  win_start,
	output logic [UW-1:0]               win_used,
	output logic                        mod_start,
	input  logic                        mod_done,
	input  logic [AW-1:0]               mod_res,
	output owbb_pkg::mem_ctl_t          mem_ctl,
	output logic [AW-1:0]               waddr,
	output logic [owbb_pkg::BYTE_W-1:0] wdata,
	output logic [AW-1:0]               raddr,
	input  logic [owbb_pkg::BYTE_W-1:0] rdata
);
	import owbb_pkg::*;

	localparam int   AW1  = AW + 1;
	localparam int   RW   = $clog2(MAX_READ + 1);
	localparam logic POW2 = ((DEPTH & (DEPTH - 1)) == 0);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MOD  = 9'b000000010,
		S_GAP  = 9'b000000100,
		S_WR   = 9'b000001000,
		S_ER   = 9'b000010000,
		S_ZERO = 9'b000100000,
		S_RDI  = 9'b001000000,
		S_RD   = 9'b010000000,
		S_RESP = 9'b100000000
	} state_t;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
		logic [AW:0] r;
		r = (s >= AW1'(DEPTH)) ? (s - AW1'(DEPTH)) : s;
		return AW'(r);
	endfunction

	state_t            state_q;
	logic [TYPE_W-1:0] type_q;
	logic [OFF_W-1:0]  off_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] data_q;
	logic [OFF_W-1:0]  start_q;
	logic [UW-1:0]     used_q;
	logic [AW-1:0]     base_q;
	logic [OFF_W-1:0]  gap_q;
	logic              le_q;
	logic [AW-1:0]     zaddr_q;
	logic [UW-1:0]     zcnt_q;
	logic              status_q;
	logic [OFF_W-1:0]  delta_q;
	logic [RW-1:0]     rcnt_q;
	logic              inside_s1;
	logic              last_s1;

	logic              accept;
	logic              empty;
	logic              bwd;
	logic              bwd_rej;
	logic              fwd_rej;
	logic [AW-1:0]     bwd_addr;
	logic [AW-1:0]     fwd_addr;
	logic [AW-1:0]     end_addr;
	logic              wr_ok;
	logic [AW-1:0]     wr_addr;
	logic [OFF_W-1:0]  used_ext;
	logic [OFF_W-1:0]  cut;
	logic              inside_now;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign win_start = start_q;
	assign win_used  = used_q;
	assign mod_start = accept && (req_type == REQ_WRITE) && (used_q == '0) && !POW2;

	assign used_ext = OFF_W'(used_q);
	assign empty    = (used_q == '0);
	// backward write: offset strictly below the window start
	assign bwd      = le_q && (gap_q != '0);
	assign bwd_rej  = gap_q > (OFF_W'(DEPTH) - used_ext);
	assign fwd_rej  = gap_q >= OFF_W'(DEPTH);
	assign bwd_addr = wrap(AW1'(base_q) + AW1'(DEPTH) - AW1'(gap_q));
	assign fwd_addr = wrap(AW1'(base_q) + AW1'(gap_q));
	assign end_addr = wrap(AW1'(base_q) + AW1'(used_q));
	assign wr_ok    = empty || (bwd ? !bwd_rej : !fwd_rej);
	assign wr_addr  = empty ? off_q[AW-1:0] : (bwd ? bwd_addr : fwd_addr);
	assign cut      = len_q - gap_q;

	// position is in the window when its distance from the start is below used
	assign inside_now = delta_q < used_ext;
	assign raddr      = wrap(AW1'(base_q) + AW1'(delta_q));

	always_comb begin
		mem_ctl  = '0;
		waddr    = zaddr_q;
		wdata    = '0;
		rsp_ctl  = '0;
		rsp_byte = '0;
		case (state_q)
			S_WR: begin
				mem_ctl.we = wr_ok;
				waddr      = wr_addr;
				wdata      = data_q;
			end
			S_MOD: begin
				mem_ctl.we = mod_done;
				waddr      = mod_res;
				wdata      = data_q;
			end
			S_ZERO: begin
				mem_ctl.we = 1'b1;
			end
			S_RDI: begin
				mem_ctl.re = 1'b1;
			end
			S_RD: begin
				rsp_ctl.load = rsp_free;
				rsp_ctl.last = last_s1;
				rsp_byte     = inside_s1 ? rdata : '0;
				mem_ctl.re   = rsp_free && !last_s1;
			end
			S_RESP: begin
				rsp_ctl.load   = rsp_free;
				rsp_ctl.status = status_q;
				rsp_ctl.last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= '0;
			used_q  <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_WRITE: begin
								state_q <= mod_start ? S_MOD : S_GAP;
							end
							REQ_READ: begin
								if (length > LEN_W'(MAX_READ) || length == '0) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_RDI;
								end
							end
							REQ_ERASE: begin
								state_q <= S_GAP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_MOD: begin
					if (mod_done) begin
						start_q <= off_q;
						base_q  <= mod_res;
						used_q  <= UW'(1);
						state_q <= S_RESP;
					end
				end
				S_GAP: begin
					state_q <= (type_q == REQ_WRITE) ? S_WR : S_ER;
				end
				S_WR: begin
					state_q <= S_RESP;
					if (empty) begin
						start_q <= off_q;
						base_q  <= off_q[AW-1:0];
						used_q  <= UW'(1);
					end else if (bwd) begin
						if (!bwd_rej) begin
							start_q <= off_q;
							base_q  <= bwd_addr;
							used_q  <= used_q + UW'(gap_q);
							if (gap_q != OFF_W'(1)) begin
								state_q <= S_ZERO;
							end
						end
					end else if (!fwd_rej) begin
						if (gap_q >= used_ext) begin
							used_q <= UW'(gap_q) + UW'(1);
						end
						if (gap_q > used_ext) begin
							state_q <= S_ZERO;
						end
					end
				end
				S_ER: begin
					state_q <= S_RESP;
					if (le_q) begin
						if (gap_q < len_q) begin
							if (cut > used_ext) begin
								start_q <= '0;
								base_q  <= '0;
								used_q  <= '0;
							end else begin
								start_q <= start_q + cut;
								base_q  <= wrap(AW1'(base_q) + AW1'(cut));
								used_q  <= used_q - UW'(cut);
							end
						end
					end else if (gap_q < used_ext) begin
						if ((used_ext - gap_q) <= len_q) begin
							used_q <= UW'(gap_q);
						end else if (len_q != '0) begin
							state_q <= S_ZERO;
						end
					end
				end
				S_ZERO: begin
					if (zcnt_q == UW'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RDI: begin
					state_q <= S_RD;
				end
				S_RD: begin
					if (rsp_free && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q   <= req_type;
			off_q    <= offset;
			len_q    <= length;
			data_q   <= data_byte;
			status_q <= (req_type == REQ_READ) && (length > LEN_W'(MAX_READ));
			delta_q  <= offset - start_q;
			rcnt_q   <= RW'(length);
		end
		if (state_q == S_GAP) begin
			le_q  <= off_q <= start_q;
			gap_q <= (off_q <= start_q) ? (start_q - off_q) : (off_q - start_q);
		end
		if (state_q == S_WR) begin
			status_q <= !wr_ok;
			if (bwd) begin
				zaddr_q <= wrap(AW1'(bwd_addr) + AW1'(1));
				zcnt_q  <= UW'(gap_q) - UW'(1);
			end else begin
				zaddr_q <= end_addr;
				zcnt_q  <= UW'(gap_q) - used_q;
			end
		end
		if (state_q == S_ER) begin
			zaddr_q <= fwd_addr;
			zcnt_q  <= UW'(len_q);
		end
		if (state_q == S_ZERO) begin
			zaddr_q <= wrap(AW1'(zaddr_q) + AW1'(1));
			zcnt_q  <= zcnt_q - UW'(1);
		end
		if (mem_ctl.re) begin
			inside_s1 <= inside_now;
			last_s1   <= (rcnt_q == RW'(1));
			delta_q   <= delta_q + OFF_W'(1);
			rcnt_q    <= rcnt_q - RW'(1);
		end
	end

endmodule
